/* rtl/epm_pkg.sv */
// Package for the entropy pool mixer: item kinds, status codes, rotate helper.
// No dependencies; used by every module of the block.
package epm_pkg;

  typedef enum logic [2:0] {
    KIND_SEED    = 3'd0,
    KIND_EXT     = 3'd1,
    KIND_LOC     = 3'd2,
    KIND_MIX     = 3'd3,
    KIND_EXTRACT = 3'd4,
    KIND_REFRESH = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_UNSEED  = 2'd2
  } status_t;

  // Classified operations handed from front to back.
  typedef enum logic [1:0] {
    OP_STATUS  = 2'd0,
    OP_MIX     = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    status_t    status;
    logic [7:0] data;
    logic [5:0] len;
  } cmd_t;

  localparam int MAX_RESULTS = 32;

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] w;
    w = {v, v} << s;
    return w[15:8];
  endfunction

endpackage

/* rtl/epm_cmd_queue.sv */
// Two-entry command queue between the front and back of the mixer.
// Depends on epm_pkg for the command type.
module epm_cmd_queue import epm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output logic not_full,
  output cmd_t head
);
  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign not_full  = (cnt_r != 2'd2);
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

/* rtl/epm_front.sv */
// Front end: takes items, fills the source buffers, tracks seed and counts,
// and queues classified commands. Depends on epm_pkg.
module epm_front import epm_pkg::*; #(
  parameter int POOL_BYTES   = 32,
  parameter int SOURCE_BYTES = 32,
  localparam int PW = $clog2(POOL_BYTES),
  localparam int SW = (SOURCE_BYTES > 1) ? $clog2(SOURCE_BYTES) : 1,
  localparam int CW = $clog2(SOURCE_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [2:0]    kind,
  input  logic [7:0]    data_byte,
  input  logic [5:0]    request_len,
  input  logic          mix_clear,
  output logic          push,
  output cmd_t          push_cmd,
  output logic          seed_we,
  output logic [PW-1:0] seed_addr,
  output logic [CW-1:0] ext_cnt,
  output logic [CW-1:0] loc_cnt,
  input  logic [SW-1:0] ext_raddr,
  input  logic [SW-1:0] loc_raddr,
  output logic [7:0]    ext_rdata,
  output logic [7:0]    loc_rdata
);
  logic [7:0]    ext_mem [SOURCE_BYTES];
  logic [7:0]    loc_mem [SOURCE_BYTES];
  logic [CW-1:0] ext_r, ext_nxt, loc_r, loc_nxt;
  logic [PW-1:0] spos_r, spos_nxt;
  logic          seeded_r, seeded_nxt;
  logic          len_bad;

  assign ext_cnt   = ext_r;
  assign loc_cnt   = loc_r;
  assign seed_addr = spos_r;
  assign seed_we   = take && (kind == KIND_SEED);
  assign len_bad   = (request_len == 6'd0) || ({26'd0, request_len} > POOL_BYTES)
                     || ({26'd0, request_len} > MAX_RESULTS);

  always_comb begin
    push = 1'b0;
    push_cmd = '{op: OP_STATUS, status: ST_OK, data: data_byte, len: request_len};
    ext_nxt = ext_r; loc_nxt = loc_r; spos_nxt = spos_r; seeded_nxt = seeded_r;
    if (mix_clear) begin
      ext_nxt = '0; loc_nxt = '0;
    end
    if (take) begin
      unique case (kind)
        KIND_SEED: begin
          if (spos_r == PW'(POOL_BYTES - 1)) begin
            spos_nxt = '0;
            seeded_nxt = 1'b1;
          end else begin
            spos_nxt = spos_r + 1'b1;
          end
        end
        KIND_EXT: if (ext_r < CW'(SOURCE_BYTES)) ext_nxt = ext_r + 1'b1;
        KIND_LOC: if (loc_r < CW'(SOURCE_BYTES)) loc_nxt = loc_r + 1'b1;
        KIND_MIX: begin
          push = 1'b1;
          if (ext_r == '0 || loc_r == '0) push_cmd.status = ST_INVALID;
          else if (!seeded_r) push_cmd.status = ST_UNSEED;
          else push_cmd.op = OP_MIX;
        end
        KIND_EXTRACT: begin
          push = 1'b1;
          if (len_bad) push_cmd.status = ST_INVALID;
          else if (!seeded_r) push_cmd.status = ST_UNSEED;
          else push_cmd.op = OP_EXTRACT;
        end
        KIND_REFRESH: begin
          push = 1'b1;
          if (!seeded_r) push_cmd.status = ST_UNSEED;
          else push_cmd.op = OP_REFRESH;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && kind == KIND_EXT && ext_r < CW'(SOURCE_BYTES))
      ext_mem[ext_r[SW-1:0]] <= data_byte;
    if (take && kind == KIND_LOC && loc_r < CW'(SOURCE_BYTES))
      loc_mem[loc_r[SW-1:0]] <= data_byte;
    ext_rdata <= ext_mem[ext_raddr];
    loc_rdata <= loc_mem[loc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= '0; loc_r <= '0; spos_r <= '0; seeded_r <= 1'b0;
    end else begin
      ext_r <= ext_nxt; loc_r <= loc_nxt; spos_r <= spos_nxt; seeded_r <= seeded_nxt;
    end
  end
endmodule

/* rtl/epm_back.sv */
// Back end: owns the pool and mix count, runs mixes, extracts and refreshes.
// Depends on epm_pkg; reads source buffers held by the front end.
module epm_back import epm_pkg::*; #(
  parameter int POOL_BYTES   = 32,
  parameter int SOURCE_BYTES = 32,
  localparam int PW = $clog2(POOL_BYTES),
  localparam int SW = (SOURCE_BYTES > 1) ? $clog2(SOURCE_BYTES) : 1,
  localparam int CW = $clog2(SOURCE_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_head,
  output logic          q_pop,
  input  logic          seed_we,
  input  logic [PW-1:0] seed_addr,
  input  logic [7:0]    seed_data,
  input  logic [CW-1:0] ext_cnt,
  input  logic [CW-1:0] loc_cnt,
  output logic [SW-1:0] ext_raddr,
  output logic [SW-1:0] loc_raddr,
  input  logic [7:0]    ext_rdata,
  input  logic [7:0]    loc_rdata,
  output logic          mix_clear,
  output logic          idle,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_last,
  output logic [63:0]   out_mixes_done
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_INJ = 5'b00010, S_DIF = 5'b00100,
    S_CPY  = 5'b01000, S_EXT = 5'b10000
  } state_t;

  logic [7:0]    pool_r [POOL_BYTES];
  logic [7:0]    nxt_r  [POOL_BYTES];
  state_t        st_r, st_nxt;
  logic [PW:0]   i_r, i_nxt;        // issue index, one ahead of write while injecting
  logic [PW-1:0] w_r;               // pending injection write index
  logic          wv_r;
  logic [SW-1:0] ei_r, li_r;        // i mod count, stepped
  logic [PW-1:0] rpos_r, rpos_nxt;
  logic [63:0]   cnt_r, cnt_nxt;
  logic [5:0]    len_r;
  logic [PW-1:0] i7, i13, ip;
  logic [PW:0]   s7, s13;
  logic [7:0]    cbyte, inj;

  assign ip    = i_r[PW-1:0];
  assign s7    = {1'b0, ip} + (PW+1)'(7);
  assign s13   = {1'b0, ip} + (PW+1)'(13);
  assign i7    = (s7 >= (PW+1)'(POOL_BYTES)) ? PW'(s7 - (PW+1)'(POOL_BYTES)) : s7[PW-1:0];
  assign i13   = (s13 >= (PW+1)'(POOL_BYTES)) ? PW'(s13 - (PW+1)'(POOL_BYTES))
                                               : s13[PW-1:0];
  assign ext_raddr = ei_r;
  assign loc_raddr = li_r;
  assign cbyte = cnt_r[{w_r[2:0], 3'b000} +: 8];
  assign inj   = pool_r[w_r] ^ rotl8(ext_rdata, w_r[2:0])
                 ^ rotl8(loc_rdata, w_r[2:0] + 3'd3) ^ cbyte;
  assign idle  = (st_r == S_IDLE);
  assign q_pop = idle && q_valid;
  assign mix_clear = (st_r == S_CPY);

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; rpos_nxt = rpos_r; cnt_nxt = cnt_r;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        i_nxt = '0;
        unique case (q_head.op)
          OP_MIX:     st_nxt = S_INJ;
          OP_EXTRACT: begin st_nxt = S_EXT; rpos_nxt = '0; end
          OP_REFRESH: rpos_nxt = (rpos_r == PW'(POOL_BYTES - 1)) ? '0 : rpos_r + 1'b1;
          default: ;
        endcase
      end
      S_INJ: begin
        if (i_r != (PW+1)'(POOL_BYTES)) i_nxt = i_r + 1'b1;
        else if (!wv_r) begin st_nxt = S_DIF; i_nxt = '0; end
      end
      S_DIF: begin
        i_nxt = i_r + 1'b1;
        if (i_r == (PW+1)'(POOL_BYTES - 1)) begin st_nxt = S_CPY; i_nxt = '0; end
      end
      S_CPY: begin st_nxt = S_IDLE; cnt_nxt = cnt_r + 64'd1; end
      S_EXT: begin
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == (PW+1)'(len_r)) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (seed_we && seed_addr == PW'(POOL_BYTES - 1)) begin
      cnt_nxt = '0; rpos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    // Source reads are registered, so the pool write lands in the cycle after its address is issued.
    wv_r <= (st_r == S_INJ) && (i_r != (PW+1)'(POOL_BYTES));
    w_r  <= ip;
    if (st_r == S_IDLE) begin
      ei_r <= '0; li_r <= '0; len_r <= q_head.len;
    end else if (st_r == S_INJ) begin
      ei_r <= (CW'(ei_r) + 1'b1 == ext_cnt) ? '0 : ei_r + 1'b1;
      li_r <= (CW'(li_r) + 1'b1 == loc_cnt) ? '0 : li_r + 1'b1;
    end
    if (seed_we) pool_r[seed_addr] <= seed_data;
    else if (wv_r) pool_r[w_r] <= inj;
    else if (st_r == S_IDLE && q_valid && q_head.op == OP_REFRESH)
      pool_r[rpos_r] <= pool_r[rpos_r] ^ rotl8(q_head.data, rpos_r[2:0] + 3'd1);
    else if (st_r == S_CPY)
      for (int k = 0; k < POOL_BYTES; k++) pool_r[k] <= nxt_r[k];
    if (st_r == S_DIF)
      nxt_r[ip] <= rotl8(pool_r[ip] ^ pool_r[i7] ^ pool_r[i13], 3'd3);
  end

  always_ff @(posedge clk) begin
    out_byte   <= '0;
    out_status <= ST_OK;
    out_last   <= 1'b1;
    if (st_r == S_IDLE && q_valid) out_status <= q_head.status;
    if (st_r == S_EXT) begin
      out_byte <= pool_r[ip];
      out_last <= (i_r + 1'b1 == (PW+1)'(len_r));
    end
    out_mixes_done <= cnt_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; rpos_r <= '0; cnt_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; rpos_r <= rpos_nxt; cnt_r <= cnt_nxt;
      out_valid <= (st_r == S_EXT) || (st_r == S_CPY) ||
                   (st_r == S_IDLE && q_valid && q_head.op == OP_STATUS);
    end
  end
endmodule

/* rtl/entropy_pool_xor_rotate_mixer.sv */
// Entropy pool mixer top level: front end, command queue and back end.
// Source, seed and count items are handled as they are taken; a mix runs an
// injection pass, a diffusion pass and a copy; an extract gives one byte a cycle.
// Status results come in the cycle after the back end takes the item; refresh gives none.
// Synchronous active-low reset clears counts, flags and queue; pool stays undefined.
// Results carry a one-cycle strobe; the receiver cannot stall.
module entropy_pool_xor_rotate_mixer import epm_pkg::*; #(
  parameter int POOL_BYTES   = 32,
  parameter int SOURCE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_request_len,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [63:0] out_mixes_done
);
  localparam int PW = $clog2(POOL_BYTES);
  localparam int SW = (SOURCE_BYTES > 1) ? $clog2(SOURCE_BYTES) : 1;
  localparam int CW = $clog2(SOURCE_BYTES + 1);

  logic          take, push, pop, q_ne, q_nf, seed_we, mix_clear, idle;
  cmd_t          push_cmd, head;
  logic [PW-1:0] seed_addr;
  logic [CW-1:0] ext_cnt, loc_cnt;
  logic [SW-1:0] ext_raddr, loc_raddr;
  logic [7:0]    ext_rdata, loc_rdata;

  // Seeds and source bytes touch state the back end uses, and a mix is classified
  // on the source counts that an earlier mix clears, so hold them all off while a
  // command is queued or running.
  assign busy = !q_nf || ((in_kind <= KIND_MIX) && (q_ne || !idle));
  assign take = start && !busy;

  epm_front #(.POOL_BYTES(POOL_BYTES), .SOURCE_BYTES(SOURCE_BYTES)) u_front (
    .clk, .rst_n, .take, .kind(in_kind), .data_byte(in_data_byte),
    .request_len(in_request_len), .mix_clear, .push, .push_cmd, .seed_we, .seed_addr,
    .ext_cnt, .loc_cnt, .ext_raddr, .loc_raddr, .ext_rdata, .loc_rdata
  );

  epm_cmd_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .not_empty(q_ne), .not_full(q_nf), .head
  );

  epm_back #(.POOL_BYTES(POOL_BYTES), .SOURCE_BYTES(SOURCE_BYTES)) u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_head(head), .q_pop(pop), .seed_we, .seed_addr,
    .seed_data(in_data_byte), .ext_cnt, .loc_cnt, .ext_raddr, .loc_raddr,
    .ext_rdata, .loc_rdata, .mix_clear, .idle, .out_valid, .out_byte, .out_status,
    .out_last, .out_mixes_done
  );
endmodule
